// ----- rtl/core/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int unsigned COUNT_LIMIT =
    (COUNT_WIDTH >= 16) ? 32'd65535 : ((32'd1 << COUNT_WIDTH) - 32'd1);

  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_DIG_0 = 8'h30;
  localparam logic [7:0] CHAR_DIG_9 = 8'h39;

  localparam int FIFO_DEPTH = 8;
  localparam int MAX_PUSH   = 3;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);
  localparam int PUSH_W     = $clog2(MAX_PUSH + 1);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic        status;
    logic [15:0] byte_count;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               room;
  } fifo_status_t;

  function automatic sextet_t sextet_of(logic [7:0] c);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = 6'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      s.value = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      s.value = 6'(c - CHAR_LO_A + 8'd26);
    end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      s.value = 6'(c - CHAR_DIG_0 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      s.value = 6'd62;
    end else if (c == CHAR_SLASH) begin
      s.value = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] total, logic [PUSH_W-1:0] n);
    logic [16:0] sum;
    sum = {1'b0, total} + 17'(n);
    if (sum > 17'(COUNT_LIMIT)) begin
      return 16'(COUNT_LIMIT);
    end
    return sum[15:0];
  endfunction

  function automatic result_t byte_result(logic [7:0] b);
    result_t r;
    r            = '0;
    r.data_byte  = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic result_t final_result(logic status, logic [15:0] count);
    result_t r;
    r            = '0;
    r.last       = 1'b1;
    r.status     = status;
    r.byte_count = count;
    return r;
  endfunction

endpackage

// ----- rtl/core/b64d_char_if.sv -----
// ----------------------------------------------------------------------------
// b64d_char_if
// Character input channel: one encoded byte per transaction.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// ----- rtl/core/b64d_result_if.sv -----
// ----------------------------------------------------------------------------
// b64d_result_if
// Result output channel: one decoded byte or final status per transaction.
// ----------------------------------------------------------------------------
interface b64d_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        last;
  logic        status;
  logic [15:0] byte_count;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  output status, output byte_count, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                input status, input byte_count, output ready);
endinterface

// ----- rtl/core/base64_decoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_decoder_top
// Base64 (standard alphabet) decoder, one character byte per transaction.
// ----------------------------------------------------------------------------
// Accepts one character per cycle while not stalled. A character is
// registered on acceptance and decoded once the result queue has room.
// Its results (zero to three) are written into an eight-entry result queue
// at the clock edge that ends the decoding cycle. Results leave one per
// cycle while the receiver is ready. The input stalls only while a
// character waits in the input register and the queue holds more than
// five results. Four characters give at most three bytes, which keeps a
// one-character-per-cycle stream flowing while results are taken unstalled.
module base64_decoder_top (
  input logic           clk,
  input logic           rst,
  b64d_char_if.sink     chars,
  b64d_result_if.source results
);

  logic        in_vld;
  logic [7:0]  in_char;
  logic [17:0] bit_accumulator;
  logic [17:0] bit_accumulator_next;
  logic [1:0]  sextet_count;
  logic [1:0]  sextet_count_next;
  logic [15:0] decoded_total;
  logic [15:0] decoded_total_next;
  logic        discarding;
  logic        discarding_next;

  b64d_pkg::fifo_status_t       fifo_st;
  b64d_pkg::result_t            push_data [b64d_pkg::MAX_PUSH];
  logic [b64d_pkg::PUSH_W-1:0]  push_n;
  logic [b64d_pkg::PUSH_W-1:0]  flush_n;
  logic                         proc;
  b64d_pkg::sextet_t            sx;
  logic [15:0]                  total_flushed;
  logic [7:0]                   flush_b0;
  logic [7:0]                   flush_b1;

  assign proc        = in_vld && fifo_st.room;
  assign chars.ready = !in_vld || fifo_st.room;

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_in;
    end
  end

  always_comb begin
    sx            = b64d_pkg::sextet_of(in_char);
    flush_n       = (sextet_count == 2'd2) ? b64d_pkg::PUSH_W'(1) :
                    (sextet_count == 2'd3) ? b64d_pkg::PUSH_W'(2) : '0;
    total_flushed = b64d_pkg::sat_add(decoded_total, flush_n);
    flush_b0      = (sextet_count == 2'd3) ? bit_accumulator[17:10] : bit_accumulator[11:4];
    flush_b1      = bit_accumulator[9:2];

    bit_accumulator_next = bit_accumulator;
    sextet_count_next    = sextet_count;
    decoded_total_next   = decoded_total;
    discarding_next      = discarding;
    push_n               = '0;
    for (int i = 0; i < b64d_pkg::MAX_PUSH; i++) begin
      push_data[i] = '0;
    end

    if (proc) begin
      if (discarding) begin
        if (in_char == b64d_pkg::CHAR_END) begin
          bit_accumulator_next = '0;
          sextet_count_next    = '0;
          decoded_total_next   = '0;
          discarding_next      = 1'b0;
        end
      end else if (in_char == b64d_pkg::CHAR_END || in_char == b64d_pkg::CHAR_PAD) begin
        push_data[0]       = b64d_pkg::byte_result(flush_b0);
        push_data[1]       = b64d_pkg::byte_result(flush_b1);
        push_data[flush_n] = b64d_pkg::final_result(1'b0, total_flushed);
        push_n             = flush_n + b64d_pkg::PUSH_W'(1);
        bit_accumulator_next = '0;
        sextet_count_next    = '0;
        if (in_char == b64d_pkg::CHAR_END) begin
          decoded_total_next = '0;
        end else begin
          decoded_total_next = total_flushed;
          discarding_next    = 1'b1;
        end
      end else if (in_char <= b64d_pkg::CHAR_SPACE) begin
        // blanks and controls: skipped
      end else if (!sx.ok) begin
        push_data[0]         = b64d_pkg::final_result(1'b1, decoded_total);
        push_n               = b64d_pkg::PUSH_W'(1);
        bit_accumulator_next = '0;
        sextet_count_next    = '0;
        discarding_next      = 1'b1;
      end else if (sextet_count == 2'd3) begin
        push_data[0]         = b64d_pkg::byte_result(bit_accumulator[17:10]);
        push_data[1]         = b64d_pkg::byte_result(bit_accumulator[9:2]);
        push_data[2]         = b64d_pkg::byte_result({bit_accumulator[1:0], sx.value});
        push_n               = b64d_pkg::PUSH_W'(3);
        decoded_total_next   = b64d_pkg::sat_add(decoded_total, b64d_pkg::PUSH_W'(3));
        bit_accumulator_next = '0;
        sextet_count_next    = '0;
      end else begin
        bit_accumulator_next = {bit_accumulator[11:0], sx.value};
        sextet_count_next    = sextet_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld          <= 1'b0;
      bit_accumulator <= '0;
      sextet_count    <= '0;
      decoded_total   <= '0;
      discarding      <= 1'b0;
    end else begin
      if (chars.valid && chars.ready) begin
        in_vld <= 1'b1;
      end else if (proc) begin
        in_vld <= 1'b0;
      end
      bit_accumulator <= bit_accumulator_next;
      sextet_count    <= sextet_count_next;
      decoded_total   <= decoded_total_next;
      discarding      <= discarding_next;
    end
  end

  b64d_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .fifo_st   (fifo_st),
    .results   (results)
  );

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != '0) |-> fifo_st.room)
    else $error("results pushed without queue room");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_st.level <= b64d_pkg::LEVEL_W'(b64d_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (proc && discarding) |-> (push_n == '0))
    else $error("result produced while discarding");

  a_final_no_byte: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.last) |-> !results.byte_valid)
    else $error("final result carries a data byte");

endmodule

// ----- rtl/core/b64d_result_fifo.sv -----
// ----------------------------------------------------------------------------
// b64d_result_fifo
// Result queue: takes up to three results per cycle, issues one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module b64d_result_fifo (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [b64d_pkg::PUSH_W-1:0]          push_n,
  input  b64d_pkg::result_t                    push_data [b64d_pkg::MAX_PUSH],
  output b64d_pkg::fifo_status_t               fifo_st,
  b64d_result_if.source                        results
);

  b64d_pkg::result_t                  mem [b64d_pkg::FIFO_DEPTH];
  logic [b64d_pkg::PTR_W-1:0]         wr_ptr;
  logic [b64d_pkg::PTR_W-1:0]         rd_ptr;
  logic [b64d_pkg::LEVEL_W-1:0]       level;
  logic                               pop;
  b64d_pkg::result_t                  head;

  assign pop  = results.valid && results.ready;
  assign head = mem[rd_ptr];

  assign results.valid      = (level != '0);
  assign results.data_byte  = head.data_byte;
  assign results.byte_valid = head.byte_valid;
  assign results.last       = head.last;
  assign results.status     = head.status;
  assign results.byte_count = head.byte_count;

  assign fifo_st.level = level;
  assign fifo_st.room  =
    (level <= b64d_pkg::LEVEL_W'(b64d_pkg::FIFO_DEPTH - b64d_pkg::MAX_PUSH));

  always_ff @(posedge clk) begin
    for (int i = 0; i < b64d_pkg::MAX_PUSH; i++) begin
      if (b64d_pkg::PUSH_W'(i) < push_n) begin
        mem[wr_ptr + b64d_pkg::PTR_W'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + b64d_pkg::PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + b64d_pkg::PTR_W'(1);
      end
      level <= level + b64d_pkg::LEVEL_W'(push_n) - b64d_pkg::LEVEL_W'(pop);
    end
  end

endmodule

// ----- test/b64d_decode_monitor.sv -----
// ----------------------------------------------------------------------------
// b64d_decode_monitor
// Watches the character and result channels of the base64 decoder. Every
// accepted character runs through a local decoder model that queues the
// results it should cause; every accepted result is compared field by field
// against the oldest queued one. Hands the outstanding and mismatch counts
// to the testbench top.
// ----------------------------------------------------------------------------
module b64d_decode_monitor (
  input  logic          clk,
  input  logic          rst,
  b64d_char_if          chars,
  b64d_result_if        results,
  output int unsigned   pending,
  output int unsigned   errors
);

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [17:0]       sextet_bits;
  logic [1:0]        sextet_cnt;
  logic [15:0]       byte_total;
  bit                skip_rest;
  b64d_pkg::result_t decoded_q[$];
  b64d_pkg::result_t got;
  b64d_pkg::result_t want;
  int unsigned       mismatch_count = 0;

  function automatic int sextet_value(logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[8*(63-i) +: 8] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      report_mismatch($sformatf("%s expected %0d, got %0d", name, exp_v, got_v));
    end
  endtask

  task automatic clear_state();
    sextet_bits = '0;
    sextet_cnt  = '0;
    byte_total  = '0;
    skip_rest   = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    b64d_pkg::result_t r;
    r            = '0;
    r.data_byte  = b;
    r.byte_valid = 1'b1;
    decoded_q.push_back(r);
    if (byte_total < b64d_pkg::COUNT_LIMIT) begin
      byte_total++;
    end
  endtask

  task automatic push_final(input logic bad);
    b64d_pkg::result_t r;
    r            = '0;
    r.last       = 1'b1;
    r.status     = bad;
    r.byte_count = byte_total;
    decoded_q.push_back(r);
  endtask

  task automatic flush_pending();
    if (sextet_cnt == 2'd2) begin
      push_byte(sextet_bits[11:4]);
    end else if (sextet_cnt == 2'd3) begin
      push_byte(sextet_bits[17:10]);
      push_byte(sextet_bits[9:2]);
    end
    sextet_bits = '0;
    sextet_cnt  = '0;
  endtask

  task automatic predict_char(input logic [7:0] c);
    int          v;
    logic [23:0] word;
    if (skip_rest) begin
      if (c == b64d_pkg::CHAR_END) begin
        clear_state();
      end
    end else if (c == b64d_pkg::CHAR_END || c == b64d_pkg::CHAR_PAD) begin
      flush_pending();
      push_final(1'b0);
      if (c == b64d_pkg::CHAR_END) begin
        clear_state();
      end else begin
        skip_rest = 1'b1;
      end
    end else if (c > b64d_pkg::CHAR_SPACE) begin
      v = sextet_value(c);
      if (v < 0) begin
        push_final(1'b1);
        sextet_bits = '0;
        sextet_cnt  = '0;
        skip_rest   = 1'b1;
      end else if (sextet_cnt == 2'd3) begin
        word = {sextet_bits, v[5:0]};
        push_byte(word[23:16]);
        push_byte(word[15:8]);
        push_byte(word[7:0]);
        sextet_bits = '0;
        sextet_cnt  = '0;
      end else begin
        sextet_bits = {sextet_bits[11:0], v[5:0]};
        sextet_cnt  = sextet_cnt + 2'd1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (chars.valid && chars.ready) begin
        predict_char(chars.char_in);
      end
      if (results.valid && results.ready) begin
        got.data_byte  = results.data_byte;
        got.byte_valid = results.byte_valid;
        got.last       = results.last;
        got.status     = results.status;
        got.byte_count = results.byte_count;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction: byte %0d valid %0b last %0b",
                                    got.data_byte, got.byte_valid, got.last));
        end else begin
          want = decoded_q.pop_front();
          check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
          check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
          check_field("last", 16'(want.last), 16'(got.last));
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("byte_count", want.byte_count, got.byte_count);
        end
      end
    end
    pending <= decoded_q.size();
    errors  <= mismatch_count;
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for base64_decoder_top. Sends a short directed set of strings
// covering the alphabet ends, blanks, padding, invalid bytes and discarding,
// then random strings, mostly well formed with some noise, under phases of
// sender gaps and receiver stalls. Checking is done by b64d_decode_monitor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int unsigned PHASE_ITEMS = 114;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b64d_char_if   char_ch();
  b64d_result_if result_ch();

  int unsigned pending;
  int unsigned errors;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned counted_items;

  logic [7:0] directed_chars [25] = '{
    b64d_pkg::CHAR_END,
    b64d_pkg::CHAR_UP_A, b64d_pkg::CHAR_SLASH, b64d_pkg::CHAR_PLUS, b64d_pkg::CHAR_LO_Z,
    8'h01, b64d_pkg::CHAR_SPACE,
    b64d_pkg::CHAR_DIG_0, b64d_pkg::CHAR_DIG_9, b64d_pkg::CHAR_LO_A, b64d_pkg::CHAR_UP_Z,
    b64d_pkg::CHAR_END,
    "T", "W", "E", b64d_pkg::CHAR_PAD, 8'h80, b64d_pkg::CHAR_END,
    "T", "Q", b64d_pkg::CHAR_END,
    "Q", "!", 8'hFF, b64d_pkg::CHAR_END
  };

  always #4 clk = ~clk;

  base64_decoder_top uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch),
    .results (result_ch)
  );

  b64d_decode_monitor decode_mon (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch),
    .results (result_ch),
    .pending (pending),
    .errors  (errors)
  );

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Called at a clock edge; returns at the edge where the transaction is taken.
  task automatic send_char(input logic [7:0] c);
    if (roll(send_idle_pct)) begin
      char_ch.valid <= 1'b0;
      do @(posedge clk); while (roll(send_idle_pct));
    end
    char_ch.valid   <= 1'b1;
    char_ch.char_in <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    counted_items++;
  endtask

  task automatic send_random_string();
    int unsigned n;
    int unsigned roll_v;
    logic [7:0]  c;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      roll_v = $urandom_range(0, 99);
      if (roll_v < 8) begin
        c = 8'($urandom_range(1, 32));
      end else if (roll_v < 12) begin
        c = 8'($urandom_range(33, 255));
      end else begin
        c = ALPHABET[8*(63 - $urandom_range(0, 63)) +: 8];
      end
      send_char(c);
    end
    if ($urandom_range(0, 99) < 35) begin
      send_char(b64d_pkg::CHAR_PAD);
      if ($urandom_range(0, 1) == 1) send_char(b64d_pkg::CHAR_PAD);
      repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(1, 255)));
    end
    send_char(b64d_pkg::CHAR_END);
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !roll(recv_stall_pct);
    end
  end

  initial begin
    char_ch.valid   <= 1'b0;
    char_ch.char_in <= b64d_pkg::CHAR_END;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_chars[i]) send_char(directed_chars[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) send_random_string();
    end
    char_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
